// File: design/eds_pkg.sv
`timescale 1ns / 1ps

package eds_pkg;

   localparam int LANES         = 4;
   localparam int SUM_WIDTH_DEF = 48;
   localparam int ELEM_W        = 16;
   localparam int SQ_W          = 2 * ELEM_W;
   localparam int LSUM_W        = SQ_W + $clog2(LANES);
   localparam int OUT_SUM_W     = 48;
   localparam int OUT_DIST_W    = 24;

   typedef logic [SQ_W-1:0] sq_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_stat_type;

endpackage

// File: design/eds_req_if.sv
`timescale 1ns / 1ps

interface eds_req_if;
   import eds_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] a_lane0;
   logic signed [ELEM_W-1:0] a_lane1;
   logic signed [ELEM_W-1:0] a_lane2;
   logic signed [ELEM_W-1:0] a_lane3;
   logic signed [ELEM_W-1:0] b_lane0;
   logic signed [ELEM_W-1:0] b_lane1;
   logic signed [ELEM_W-1:0] b_lane2;
   logic signed [ELEM_W-1:0] b_lane3;
   logic                     last_slice;

   modport source (
      output valid, a_lane0, a_lane1, a_lane2, a_lane3,
             b_lane0, b_lane1, b_lane2, b_lane3, last_slice,
      input  ready
   );

   modport sink (
      input  valid, a_lane0, a_lane1, a_lane2, a_lane3,
             b_lane0, b_lane1, b_lane2, b_lane3, last_slice,
      output ready
   );

endinterface

// File: design/eds_rsp_if.sv
`timescale 1ns / 1ps

interface eds_rsp_if;
   import eds_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OUT_SUM_W-1:0]  sum_of_squares;
   logic [OUT_DIST_W-1:0] distance;
   logic                  overflowed;

   modport source (
      output valid, sum_of_squares, distance, overflowed,
      input  ready
   );

   modport sink (
      input  valid, sum_of_squares, distance, overflowed,
      output ready
   );

endinterface

// File: design/eds_lane.sv
`timescale 1ns / 1ps

module eds_lane
   import eds_pkg::*;
(
   input  logic                     clock,
   input  logic                     load,
   input  logic signed [ELEM_W-1:0] a,
   input  logic signed [ELEM_W-1:0] b,
   output sq_type                   sq
);

   logic signed [ELEM_W:0] diff;
   logic [ELEM_W-1:0]      mag;
   sq_type                 sq_ff;
   sq_type                 sq_in;

   always_comb begin
      diff  = {a[ELEM_W-1], a} - {b[ELEM_W-1], b};
      // |a-b| never exceeds 2^16-1, so it fits the element width unsigned
      mag   = diff[ELEM_W] ? ELEM_W'(-diff) : diff[ELEM_W-1:0];
      sq_in = load ? mag * mag : sq_ff;
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   assign sq = sq_ff;

endmodule

// File: design/eds_merge.sv
`timescale 1ns / 1ps

module eds_merge
   import eds_pkg::*;
#(
   parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 s1_valid,
   input  logic                 s1_last,
   input  sq_type               sq [LANES],
   output logic                 start,
   output logic [SUM_WIDTH-1:0] total,
   output logic                 sat,
   output logic                 busy
);

   localparam int AW = SUM_WIDTH + 1;

   logic [LSUM_W-1:0]    lsum_in;
   logic [LSUM_W-1:0]    lsum_ff;
   logic                 s2_valid_ff;
   logic                 s2_valid_in;
   logic                 s2_last_ff;
   logic                 s2_last_in;
   logic [SUM_WIDTH-1:0] run_ff;
   logic [SUM_WIDTH-1:0] run_in;
   logic                 sat_ff;
   logic                 sat_in;
   logic [AW-1:0]        acc;
   logic [SUM_WIDTH-1:0] sum_sat;
   logic                 sat_now;

   // lane reduction, registered before the accumulator
   always_comb begin
      lsum_in = '0;
      for (int i = 0; i < LANES; i++) begin
         lsum_in = lsum_in + LSUM_W'(sq[i]);
      end
      s2_valid_in = s1_valid;
      s2_last_in  = s1_last;
   end

   always_comb begin
      acc     = {1'b0, run_ff} + AW'(lsum_ff);
      // carry out means the sum passed the largest value: clamp
      sum_sat = acc[SUM_WIDTH] ? '1 : acc[SUM_WIDTH-1:0];
      sat_now = sat_ff | acc[SUM_WIDTH];
      run_in  = run_ff;
      sat_in  = sat_ff;
      start   = 1'b0;
      if (s2_valid_ff) begin
         if (s2_last_ff) begin
            run_in = '0;
            sat_in = 1'b0;
            start  = 1'b1;
         end else begin
            run_in = sum_sat;
            sat_in = sat_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      lsum_ff    <= lsum_in;
      s2_last_ff <= s2_last_in;
      if (reset) begin
         s2_valid_ff <= 1'b0;
         run_ff      <= '0;
         sat_ff      <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         run_ff      <= run_in;
         sat_ff      <= sat_in;
      end
   end

   assign total = sum_sat;
   assign sat   = sat_now;
   assign busy  = s2_valid_ff & s2_last_ff;

endmodule

// File: design/eds_sqrt.sv
`timescale 1ns / 1ps

module eds_sqrt
   import eds_pkg::*;
#(
   parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SUM_WIDTH-1:0]           operand,
   input  logic                           sat_in,
   input  logic                           take,
   output sqrt_stat_type                  stat,
   output logic [(SUM_WIDTH+1)/2-1:0]     root,
   output logic [SUM_WIDTH-1:0]           sum_out,
   output logic                           sat_out
);

   localparam int ROOT_W = (SUM_WIDTH + 1) / 2;
   localparam int OPW    = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   typedef enum logic [2:0] {
      SQ_IDLE = 3'b001,
      SQ_CALC = 3'b010,
      SQ_DONE = 3'b100
   } sqrt_state_type;

   sqrt_state_type       state_ff, state_in;
   logic [OPW-1:0]       op_ff, op_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic                 sat_ff, sat_next;
   logic [REM_W-1:0]     rem_sh;
   logic [REM_W-1:0]     trial;
   logic                 ge;

   // one result bit per cycle, restoring method
   always_comb begin
      rem_sh   = {rem_ff[REM_W-3:0], op_ff[OPW-1:OPW-2]};
      trial    = {root_ff, 2'b01};
      ge       = rem_sh >= trial;
      state_in = state_ff;
      op_in    = op_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      sat_next = sat_ff;
      unique case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               op_in    = OPW'(operand);
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               sum_in   = operand;
               sat_next = sat_in;
               state_in = SQ_CALC;
            end
         end
         SQ_CALC: begin
            rem_in  = ge ? rem_sh - trial : rem_sh;
            root_in = {root_ff[ROOT_W-2:0], ge};
            op_in   = {op_ff[OPW-3:0], 2'b00};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               state_in = SQ_DONE;
            end
         end
         SQ_DONE: begin
            if (take) begin
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      sum_ff  <= sum_in;
      sat_ff  <= sat_next;
      if (reset) begin
         state_ff <= SQ_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // busy is the upper field, done the lower
   assign stat      = {(state_ff != SQ_IDLE), (state_ff == SQ_DONE)};
   assign root      = root_ff;
   assign sum_out   = sum_ff;
   assign sat_out   = sat_ff;

endmodule

// File: design/euclidean_distance_stream.sv
`timescale 1ns / 1ps
// a result beat passes from its last slice through the lane, merge, square root and output registers
// throughput: one slice per cycle inside a vector pair; after a last slice the next beat is
//   taken once the bit-serial square root unit (one root bit per cycle) hands off its result
// reset: synchronous, active high; clears the running sum, the saturation flag and all valids

module euclidean_distance_stream
   import eds_pkg::*;
#(
   parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   eds_req_if.sink   req_bus,
   eds_rsp_if.source rsp_bus
);

   localparam int ROOT_W = (SUM_WIDTH + 1) / 2;

   logic signed [ELEM_W-1:0] a_arr [LANES];
   logic signed [ELEM_W-1:0] b_arr [LANES];
   sq_type                   sq [LANES];
   logic                     req_fire;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_last_ff, s1_last_in;
   logic                     m_start;
   logic [SUM_WIDTH-1:0]     m_total;
   logic                     m_sat;
   logic                     m_busy;
   sqrt_stat_type            sq_stat;
   logic [ROOT_W-1:0]        sq_root;
   logic [SUM_WIDTH-1:0]     sq_sum;
   logic                     sq_sat;
   logic                     take;
   logic                     out_valid_ff, out_valid_in;
   logic [OUT_SUM_W-1:0]     out_sum_ff, out_sum_in;
   logic [OUT_DIST_W-1:0]    out_dist_ff, out_dist_in;
   logic                     out_ovf_ff, out_ovf_in;

   assign a_arr[0] = req_bus.a_lane0;
   assign a_arr[1] = req_bus.a_lane1;
   assign a_arr[2] = req_bus.a_lane2;
   assign a_arr[3] = req_bus.a_lane3;
   assign b_arr[0] = req_bus.b_lane0;
   assign b_arr[1] = req_bus.b_lane1;
   assign b_arr[2] = req_bus.b_lane2;
   assign b_arr[3] = req_bus.b_lane3;

   // hold off while a last slice is in flight or the root unit is occupied
   assign req_bus.ready = !(s1_valid_ff && s1_last_ff) && !m_busy && !sq_stat.busy;
   assign req_fire      = req_bus.valid && req_bus.ready;

   generate
      for (genvar g = 0; g < LANES; g++) begin : g_lane
         eds_lane u_lane (
            .clock (clock),
            .load  (req_fire),
            .a     (a_arr[g]),
            .b     (b_arr[g]),
            .sq    (sq[g])
         );
      end
   endgenerate

   always_comb begin
      s1_valid_in = req_fire;
      s1_last_in  = req_bus.last_slice;
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= s1_last_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   eds_merge #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid_ff),
      .s1_last  (s1_last_ff),
      .sq       (sq),
      .start    (m_start),
      .total    (m_total),
      .sat      (m_sat),
      .busy     (m_busy)
   );

   eds_sqrt #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (m_start),
      .operand (m_total),
      .sat_in  (m_sat),
      .take    (take),
      .stat    (sq_stat),
      .root    (sq_root),
      .sum_out (sq_sum),
      .sat_out (sq_sat)
   );

   // output register frees the root unit while a beat waits downstream
   always_comb begin
      take         = sq_stat.done && (!out_valid_ff || rsp_bus.ready);
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_sum_in   = out_sum_ff;
      out_dist_in  = out_dist_ff;
      out_ovf_in   = out_ovf_ff;
      if (take) begin
         out_valid_in = 1'b1;
         out_sum_in   = OUT_SUM_W'(sq_sum);
         out_dist_in  = OUT_DIST_W'(sq_root);
         out_ovf_in   = sq_sat;
      end
   end

   always_ff @(posedge clock) begin
      out_sum_ff  <= out_sum_in;
      out_dist_ff <= out_dist_in;
      out_ovf_ff  <= out_ovf_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.sum_of_squares = out_sum_ff;
   assign rsp_bus.distance       = out_dist_ff;
   assign rsp_bus.overflowed     = out_ovf_ff;

   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.last_slice |=> !req_bus.ready)
      else $error("beat accepted right behind a last slice");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      m_start |-> !sq_stat.busy)
      else $error("root unit started while busy");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      sq_stat.done && out_valid_ff && !rsp_bus.ready |=> sq_stat.done)
      else $error("root result dropped while output stalled");

   a_last_reaches_merge: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff |=> m_busy)
      else $error("last slice lost between lanes and merge");

endmodule

// File: tb/euclidean_distance_stream_test.sv
`timescale 1ns / 1ps

import eds_pkg::*;

typedef struct packed {
   logic                         last;
   logic [LANES-1:0][ELEM_W-1:0] a;
   logic [LANES-1:0][ELEM_W-1:0] b;
} slice_type;

typedef struct packed {
   logic [OUT_SUM_W-1:0]  sum_of_squares;
   logic [OUT_DIST_W-1:0] distance;
   logic                  overflowed;
} distance_result_type;

typedef enum int {
   FILL_MIXED,
   FILL_SMALL,
   FILL_EXTREME
} fill_kind_type;

class distance_board;
   bit [63:0]           acc;
   bit                  acc_saturated;
   bit [63:0]           acc_ceiling;
   distance_result_type expected_results[$];
   int                  errors;
   int                  slices;
   int                  pairs;
   int                  saturated_pairs;
   int                  checked;

   function new();
      acc_ceiling = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - SUM_WIDTH_DEF);
   endfunction

   // bit-by-bit search, root of a 48-bit sum fits in 24 bits
   function bit [63:0] floor_root(bit [63:0] n);
      bit [63:0] root;
      bit [63:0] trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   function int pending();
      return expected_results.size();
   endfunction

   function void note_slice(slice_type s);
      longint              diff;
      bit [63:0]           sq;
      bit [63:0]           root;
      distance_result_type r;
      slices++;
      for (int lane = 0; lane < LANES; lane++) begin
         diff = longint'($signed(s.a[lane])) - longint'($signed(s.b[lane]));
         sq = (diff < 0) ? 64'(-diff) : 64'(diff);
         sq = sq * sq;
         if (sq > acc_ceiling - acc) begin
            acc = acc_ceiling;
            acc_saturated = 1'b1;
         end else begin
            acc += sq;
         end
      end
      if (s.last) begin
         root = floor_root(acc);
         r.sum_of_squares = acc[OUT_SUM_W-1:0];
         r.distance = root[OUT_DIST_W-1:0];
         r.overflowed = acc_saturated;
         expected_results.push_back(r);
         pairs++;
         if (acc_saturated) saturated_pairs++;
         acc = 0;
         acc_saturated = 1'b0;
      end
   endfunction

   task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   task check_result(distance_result_type got);
      distance_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result beat with no vector pair outstanding");
      end else begin
         want = expected_results.pop_front();
         checked++;
         if (got.sum_of_squares !== want.sum_of_squares)
            report_mismatch($sformatf("sum_of_squares %h, want %h",
                                      got.sum_of_squares, want.sum_of_squares));
         if (got.distance !== want.distance)
            report_mismatch($sformatf("distance %h, want %h", got.distance, want.distance));
         if (got.overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed %b, want %b",
                                      got.overflowed, want.overflowed));
      end
   endtask
endclass

module euclidean_distance_stream_test;
   localparam int LIMIT = 1_000_000;

   logic          clock;
   logic          reset;
   bit            calm = 1'b0;
   int unsigned   cycles = 0;
   distance_board board = new();

   eds_req_if req_bus();
   eds_rsp_if rsp_bus();

   euclidean_distance_stream i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_result(distance_result_type'({rsp_bus.sum_of_squares,
                                                   rsp_bus.distance,
                                                   rsp_bus.overflowed}));
   end

   initial begin
      wait (cycles >= LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycles, board.pending());
      $display("end of test: mismatches");
      $finish;
   end

   // result side back-pressure, with a rare long stall
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_bus.ready = 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else if ($urandom_range(199) == 0) begin
            rsp_bus.ready = 1'b0;
            hold = $urandom_range(20, 60);
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= 20);
            hold = $urandom_range(0, 5);
         end
      end
   end

   function automatic int pick_gap();
      if (calm) return 0;
      if ($urandom_range(199) == 0) return $urandom_range(20, 60);
      if ($urandom_range(99) < 20) return $urandom_range(1, 4);
      return 0;
   endfunction

   function automatic logic [ELEM_W-1:0] rand_elem(fill_kind_type kind);
      if (kind == FILL_SMALL) return 16'($urandom_range(0, 511) - 256);
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3, 4: return 16'($urandom_range(0, 511) - 256);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic slice_type random_slice(fill_kind_type kind);
      slice_type s;
      s.last = 1'b0;
      for (int lane = 0; lane < LANES; lane++) begin
         if (kind == FILL_EXTREME) begin
            // largest possible difference, either sign
            s.a[lane] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            s.b[lane] = ~s.a[lane];
         end else begin
            s.a[lane] = rand_elem(kind);
            s.b[lane] = ($urandom_range(7) == 0) ? s.a[lane] : rand_elem(kind);
         end
      end
      return s;
   endfunction

   function automatic slice_type uniform(logic [ELEM_W-1:0] av, logic [ELEM_W-1:0] bv,
                                         logic last);
      slice_type s;
      s.last = last;
      for (int lane = 0; lane < LANES; lane++) begin
         s.a[lane] = av;
         s.b[lane] = bv;
      end
      return s;
   endfunction

   task automatic put_slice(slice_type s);
      req_bus.a_lane0    = s.a[0];
      req_bus.a_lane1    = s.a[1];
      req_bus.a_lane2    = s.a[2];
      req_bus.a_lane3    = s.a[3];
      req_bus.b_lane0    = s.b[0];
      req_bus.b_lane1    = s.b[1];
      req_bus.b_lane2    = s.b[2];
      req_bus.b_lane3    = s.b[3];
      req_bus.last_slice = s.last;
   endtask

   // entered and left at a falling edge; valid stays high into the next beat
   task automatic send_slice(slice_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      put_slice(s);
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      board.note_slice(s);
      @(negedge clock);
   endtask

   task automatic send_pair(int len, fill_kind_type kind);
      slice_type s;
      for (int i = 0; i < len; i++) begin
         s = random_slice(kind);
         s.last = (i == len - 1);
         send_slice(s);
      end
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (board.pending() > 0) @(negedge clock);
   endtask

   initial begin
      slice_type     s;
      int            sent;
      int            pair_no;
      int            len;
      fill_kind_type kind;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      put_slice(uniform(16'h0000, 16'h0000, 1'b0));
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // single-slice pairs at the extremes
      send_slice(uniform(16'h0000, 16'h0000, 1'b1));
      send_slice(uniform(16'h7FFF, 16'h8000, 1'b1));
      send_slice(uniform(16'h8000, 16'h7FFF, 1'b1));
      send_slice(uniform(16'h1234, 16'h1234, 1'b1));
      // sums of 1..4 units, roots exact and inexact
      for (int k = 1; k <= LANES; k++) begin
         s = uniform(16'h0000, 16'h0000, 1'b1);
         for (int lane = 0; lane < k; lane++) s.a[lane] = 16'h0001;
         send_slice(s);
      end
      s = uniform(16'h0000, 16'h0000, 1'b1);
      s.b[3] = 16'h0100;
      send_slice(s);
      // one lane at a time across a four-beat pair
      for (int lane = 0; lane < LANES; lane++) begin
         s = uniform(16'h0000, 16'h0000, lane == LANES - 1);
         s.a[lane] = 16'h8000;
         s.b[lane] = 16'h7FFF;
         send_slice(s);
      end
      send_pair(3, FILL_MIXED);

      sent = 0;
      pair_no = 0;
      while (sent < 1300) begin
         len = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 24);
         kind = ($urandom_range(5) == 0) ? FILL_SMALL :
                (($urandom_range(9) == 0) ? FILL_EXTREME : FILL_MIXED);
         calm = (sent >= 500 && sent < 750);
         if (pair_no == 40) drain();
         send_pair(len, kind);
         sent += len;
         pair_no++;
      end
      calm = 1'b0;

      drain();
      repeat (40) @(negedge clock);
      $display("streamed %0d slices in %0d vector pairs, %0d of them saturating",
               board.slices, board.pairs, board.saturated_pairs);
      $display("checked %0d distance results, %0d mismatches", board.checked, board.errors);
      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/eds_pkg.sv
design/eds_req_if.sv
design/eds_rsp_if.sv
design/eds_lane.sv
design/eds_merge.sv
design/eds_sqrt.sv
design/euclidean_distance_stream.sv
tb/euclidean_distance_stream_test.sv
